### rtl/hashed_pair_key_permission_lookup_assert.svh
// Assertion macros shared by the pair-key permission lookup RTL.
`ifndef HASHED_PAIR_KEY_PERMISSION_LOOKUP_ASSERT_SVH
`define HASHED_PAIR_KEY_PERMISSION_LOOKUP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define HPKPL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpkpl: same-cycle check failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define HPKPL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpkpl: next-cycle check failed");
`else
`define HPKPL_ASSERT_NOW(lbl, ante, cons)
`define HPKPL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/hpkpl_pkg.sv
// Package with the types, constants and codes of the pair-key permission lookup.
package hpkpl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 64;
    localparam int FLAG_W      = 32;
    localparam int SLOT_W      = 10;
    localparam int CFG_W       = 4;
    localparam int HASH_W      = 32;

    localparam logic [CFG_W-1:0]  SIZE_LOG2_MIN   = 4'd4;
    localparam logic [CFG_W-1:0]  SIZE_LOG2_RESET = 4'd10;
    localparam logic [HASH_W-1:0] FNV_BASIS       = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME       = 32'd16777619;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_SEEK,
        ST_PROBE,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clear_step;
        logic hash_step;
        logic seek;
        logic probe_step;
        logic write_slot;
        logic finish;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_write;
        logic in_key_special;
        logic clear_last;
        logic hash_last;
        logic probe_hit;
        logic probe_stop;
        logic out_free;
    } status_t;

endpackage

### rtl/hashed_pair_key_permission_lookup.sv
// Top level of the pair-key permission lookup: controller, datapath and checks.
//
//  Channel   Handshake               Payload
//  --------  ----------------------  ----------------------------------------------
//  in        in_valid / in_stall     cmd, slot_index, visitor_key, owner_key, flags
//  out       out_valid / out_stall   permission, found
//  cfg       cfg_valid / cfg_ready   cfg_data (table_size_log2)
//
// A write beat passes from IDLE through WRITE and DONE back to IDLE. A lookup
// beat passes through HASH, SEEK, PROBE and DONE: HASH runs the FNV-1a hash over
// the eight key bytes, one round and one 32-bit multiply per cycle, and the
// probe loop then reads one slot a cycle from the visitor and owner tables.
// A lookup of visitor 0 or all ones goes straight to DONE and does no probing.
// After reset the visitor table is cleared one slot a cycle with in_stall held
// high; configuration writes are taken throughout.
// A stalled result waits in the output register while the next beat is accepted.
`include "hashed_pair_key_permission_lookup_assert.svh"

module hashed_pair_key_permission_lookup (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            cmd,
    input  logic [hpkpl_pkg::SLOT_W-1:0]    slot_index,
    input  logic [hpkpl_pkg::KEY_W-1:0]     visitor_key,
    input  logic [hpkpl_pkg::KEY_W-1:0]     owner_key,
    input  logic [hpkpl_pkg::FLAG_W-1:0]    flags,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [hpkpl_pkg::FLAG_W-1:0]    permission,
    output logic                            found,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hpkpl_pkg::CFG_W-1:0]     cfg_data
);

    import hpkpl_pkg::*;

    ctrl_t   ctrl;
    status_t status;
    logic    cfg_we;

    // The size register can be written at any time; it is only meant to change
    // while no beat is in flight.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    hpkpl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .ctrl     (ctrl)
    );

    hpkpl_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .slot_index  (slot_index),
        .visitor_key (visitor_key),
        .owner_key   (owner_key),
        .flags       (flags),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .ctrl        (ctrl),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .permission  (permission),
        .found       (found)
    );

    // No input beat may be taken while the visitor table is being cleared.
    `HPKPL_ASSERT_NOW(a_no_accept_in_clear, ctrl.clear_step, in_stall)
    // A result is only loaded when the output register is free.
    `HPKPL_ASSERT_NOW(a_finish_when_free, ctrl.finish, !out_valid || !out_stall)
    // An accepted beat keeps the block busy in the following cycle.
    `HPKPL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // The probe loop and the write path never run together.
    `HPKPL_ASSERT_NOW(a_probe_excl_write, ctrl.probe_step, !ctrl.write_slot && !ctrl.clear_step)

endmodule

### rtl/hpkpl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module hpkpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/hpkpl_ctrl.sv
// Controller state machine of the pair-key permission lookup.
module hpkpl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  hpkpl_pkg::status_t status,
    output hpkpl_pkg::ctrl_t   ctrl
);

    import hpkpl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                ctrl.accept = in_valid;
                if (in_valid)
                begin
                    if (status.in_is_write)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (status.in_key_special)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                ctrl.hash_step = 1'b1;
                if (status.hash_last)
                begin
                    state_next = ST_SEEK;
                end
            end
            ST_SEEK:
            begin
                ctrl.seek  = 1'b1;
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                ctrl.probe_step = 1'b1;
                if (status.probe_hit || status.probe_stop)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WRITE:
            begin
                ctrl.write_slot = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

### rtl/hpkpl_datapath.sv
// Datapath of the pair-key permission lookup: item registers, hash, probe and tables.
module hpkpl_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd,
    input  logic [hpkpl_pkg::SLOT_W-1:0]    slot_index,
    input  logic [hpkpl_pkg::KEY_W-1:0]     visitor_key,
    input  logic [hpkpl_pkg::KEY_W-1:0]     owner_key,
    input  logic [hpkpl_pkg::FLAG_W-1:0]    flags,
    input  logic                            cfg_we,
    input  logic [hpkpl_pkg::CFG_W-1:0]     cfg_data,
    input  hpkpl_pkg::ctrl_t                ctrl,
    output hpkpl_pkg::status_t              status,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [hpkpl_pkg::FLAG_W-1:0]    permission,
    output logic                            found
);

    import hpkpl_pkg::*;

    localparam int META_W = KEY_W + FLAG_W;

    // Control registers.
    logic [CFG_W-1:0]  size_log2_reg;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [2:0]        byte_idx_reg, byte_idx_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers.
    logic              cmd_reg, cmd_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [KEY_W-1:0]  vid_reg, vid_next;
    logic [KEY_W-1:0]  oid_reg, oid_next;
    logic [FLAG_W-1:0] flags_reg, flags_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [ADDR_W-1:0] probe_reg, probe_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [FLAG_W-1:0] res_perm_reg, res_perm_next;
    logic              res_found_reg, res_found_next;
    logic [FLAG_W-1:0] perm_reg, perm_next;
    logic              found_reg, found_next;

    logic [CFG_W-1:0]  size_log2;
    logic [ADDR_W:0]   cap;
    logic [ADDR_W-1:0] mask;
    logic [KEY_W-1:0]  mix;
    logic [7:0]        mix_byte;
    logic [HASH_W-1:0] hash_xor;
    logic [HASH_W-1:0] hash_mul;

    logic              vis_we;
    logic [ADDR_W-1:0] vis_waddr;
    logic [KEY_W-1:0]  vis_wdata;
    logic [KEY_W-1:0]  vis_rdata;
    logic [META_W-1:0] meta_rdata;
    logic              slot_empty;
    logic              slot_match;

    // Active table size, held to the supported range.
    always_comb
    begin
        if (size_log2_reg < SIZE_LOG2_MIN)
        begin
            size_log2 = SIZE_LOG2_MIN;
        end
        else if (32'(size_log2_reg) > ADDR_W)
        begin
            size_log2 = CFG_W'(ADDR_W);
        end
        else
        begin
            size_log2 = size_log2_reg;
        end
        cap  = (ADDR_W + 1)'(1) << size_log2;
        mask = ADDR_W'(cap - 1'b1);
    end

    // One FNV-1a round per cycle over the mixed key, lowest byte first.
    assign mix      = vid_reg ^ {oid_reg[31:0], oid_reg[63:32]};
    assign mix_byte = mix[{byte_idx_reg, 3'b000} +: 8];
    assign hash_xor = hash_reg ^ {24'd0, mix_byte};
    assign hash_mul = hash_xor * FNV_PRIME;

    assign slot_empty = (vis_rdata == '0);
    assign slot_match = (vis_rdata == vid_reg) && (meta_rdata[META_W-1:FLAG_W] == oid_reg);

    always_comb
    begin
        cmd_next       = cmd_reg;
        slot_next      = slot_reg;
        vid_next       = vid_reg;
        oid_next       = oid_reg;
        flags_next     = flags_reg;
        hash_next      = hash_reg;
        byte_idx_next  = byte_idx_reg;
        probe_next     = probe_reg;
        cnt_next       = cnt_reg;
        res_perm_next  = res_perm_reg;
        res_found_next = res_found_reg;
        clr_next       = clr_reg;

        if (ctrl.clear_step)
        begin
            clr_next = clr_reg + 1'b1;
        end
        if (ctrl.accept)
        begin
            cmd_next       = cmd;
            slot_next      = slot_index;
            vid_next       = visitor_key;
            oid_next       = owner_key;
            flags_next     = flags;
            hash_next      = FNV_BASIS;
            byte_idx_next  = '0;
            res_perm_next  = '0;
            res_found_next = 1'b0;
        end
        if (ctrl.hash_step)
        begin
            hash_next     = hash_mul;
            byte_idx_next = byte_idx_reg + 1'b1;
        end
        if (ctrl.seek)
        begin
            probe_next = ADDR_W'(hash_reg) & mask;
            cnt_next   = '0;
        end
        if (ctrl.probe_step)
        begin
            if (slot_match)
            begin
                res_perm_next  = meta_rdata[FLAG_W-1:0];
                res_found_next = 1'b1;
            end
            else if (!status.probe_stop)
            begin
                probe_next = (probe_reg + 1'b1) & mask;
                cnt_next   = cnt_reg + 1'b1;
            end
        end
    end

    // Result register towards the output channel.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        perm_next      = perm_reg;
        found_next     = found_reg;
        if (ctrl.finish)
        begin
            out_valid_next = 1'b1;
            perm_next      = res_perm_reg;
            found_next     = res_found_reg;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= SIZE_LOG2_RESET;
            clr_reg       <= '0;
            byte_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_log2_reg <= cfg_data;
            end
            clr_reg       <= clr_next;
            byte_idx_reg  <= byte_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        slot_reg      <= slot_next;
        vid_reg       <= vid_next;
        oid_reg       <= oid_next;
        flags_reg     <= flags_next;
        hash_reg      <= hash_next;
        probe_reg     <= probe_next;
        cnt_reg       <= cnt_next;
        res_perm_reg  <= res_perm_next;
        res_found_reg <= res_found_next;
        perm_reg      <= perm_next;
        found_reg     <= found_next;
    end

    // The visitor table is swept to zero after reset and shares its write port with writes.
    assign vis_we    = ctrl.clear_step | ctrl.write_slot;
    assign vis_waddr = ctrl.clear_step ? clr_reg : ADDR_W'(slot_reg);
    assign vis_wdata = ctrl.clear_step ? '0 : vid_reg;

    hpkpl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_visitor_ram (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (probe_next),
        .rdata (vis_rdata)
    );

    hpkpl_ram #(
        .WIDTH (META_W),
        .DEPTH (TABLE_DEPTH)
    ) u_meta_ram (
        .clk   (clk),
        .we    (ctrl.write_slot),
        .waddr (ADDR_W'(slot_reg)),
        .wdata ({oid_reg, flags_reg}),
        .raddr (probe_next),
        .rdata (meta_rdata)
    );

    always_comb
    begin
        status.in_is_write    = (cmd == CMD_WRITE);
        status.in_key_special = (visitor_key == '0) || (visitor_key == '1);
        status.clear_last     = (clr_reg == ADDR_W'(TABLE_DEPTH - 1));
        status.hash_last      = (byte_idx_reg == '1) && (cmd_reg == CMD_LOOKUP);
        status.probe_hit      = slot_match;
        status.probe_stop     = slot_empty || (cnt_reg == mask);
        status.out_free       = !out_valid_reg || !out_stall;
    end

    assign out_valid  = out_valid_reg;
    assign permission = perm_reg;
    assign found      = found_reg;

endmodule
